>>> rtl/dph_pkg.sv
// ----------------------------------------------------------------------------
// dph_pkg
// Shared types and codes for the distance pair histogram.
// ----------------------------------------------------------------------------
package dph_pkg;

   localparam logic [1:0] ACT_SITE  = 2'd0;
   localparam logic [1:0] ACT_SET   = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;
   localparam logic [1:0] ACT_SPARE = 2'd3;

   localparam int TAG_BITS = 16;

   // Table sizes; the ring index and count address are the low bits.
   localparam int PROFILE_COUNT = 64;
   localparam int WINDOW_DEPTH  = 1024;
   localparam int COUNT_BITS    = 32;

   // Queued item from the front part to the back part.
   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] position;
      logic [5:0]  profile;
      logic [5:0]  other_profile;
      logic        new_contig;
      logic        include_value;
   } item_type;

endpackage

>>> rtl/distance_pair_histogram_core.sv
// ----------------------------------------------------------------------------
// distance_pair_histogram_core
// Counts profile pairs of sites a fixed distance apart.
// ----------------------------------------------------------------------------
// Each item passes through the back sequencer steps (ring read, count read,
// write, result); a new item is taken only after the result of the last one
// has been taken, and a two-entry queue holds arriving items meanwhile. After
// reset a clearing pass runs over the ring and the count table before the
// first item is taken.
module distance_pair_histogram_core
   import dph_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [9:0]  csr_pair_distance,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_position,
   input  logic [5:0]  req_profile,
   input  logic [5:0]  req_other_profile,
   input  logic        req_new_contig,
   input  logic        req_include_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_pair_found,
   output logic [5:0]  rsp_low_profile,
   output logic [5:0]  rsp_high_profile,
   output logic [31:0] rsp_pair_count,
   output logic [31:0] rsp_total_pairs
);

   logic [9:0] dist_ff;
   item_type   req_item, q_item;
   logic       q_valid, q_take;

   // Hold the distance register.
   always_ff @(posedge clock) begin
      if (reset) begin
         dist_ff <= 10'd1;
      end else if (csr_write) begin
         dist_ff <= csr_pair_distance;
      end
   end

   assign req_item = '{action: req_action, position: req_position,
                       profile: req_profile, other_profile: req_other_profile,
                       new_contig: req_new_contig,
                       include_value: req_include_value};

   dph_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_stall(req_stall), .in_item(req_item),
      .out_valid(q_valid), .out_take(q_take), .out_item(q_item)
   );

   dph_back u_back (
      .clock(clock), .reset(reset), .distance(dist_ff),
      .in_valid(q_valid), .in_take(q_take), .in_item(q_item),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_pair_found(rsp_pair_found), .rsp_low_profile(rsp_low_profile),
      .rsp_high_profile(rsp_high_profile), .rsp_pair_count(rsp_pair_count),
      .rsp_total_pairs(rsp_total_pairs)
   );

endmodule

>>> rtl/dph_front.sv
// ----------------------------------------------------------------------------
// dph_front
// Two-entry item queue between the input channel and the back part.
// ----------------------------------------------------------------------------
module dph_front
   import dph_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_stall,
   input  item_type in_item,
   output logic     out_valid,
   input  logic     out_take,
   output item_type out_item
);

   item_type   q_ff [2];
   item_type   q_in [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_stall  = (cnt_ff == 2'd2);
   assign push      = in_valid && !in_stall;
   assign out_valid = (cnt_ff != 2'd0);
   assign pop       = out_valid && out_take;
   assign out_item  = q_ff[0];

   // Shift on pop, append at the fill level.
   always_comb begin
      q_in   = q_ff;
      cnt_in = cnt_ff;
      if (pop) begin
         q_in[0] = q_ff[1];
         cnt_in  = cnt_in - 2'd1;
      end
      if (push) begin
         q_in[cnt_in[0]] = in_item;
         cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

>>> rtl/dph_back.sv
// ----------------------------------------------------------------------------
// dph_back
// Sequencer that runs one item: ring lookup, count read-modify-write, result.
// ----------------------------------------------------------------------------
module dph_back
   import dph_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [9:0]  distance,
   input  logic        in_valid,
   output logic        in_take,
   input  item_type    in_item,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_pair_found,
   output logic [5:0]  rsp_low_profile,
   output logic [5:0]  rsp_high_profile,
   output logic [31:0] rsp_pair_count,
   output logic [31:0] rsp_total_pairs
);

   localparam int WB  = $clog2(WINDOW_DEPTH);
   localparam int PB  = $clog2(PROFILE_COUNT);
   localparam int CB  = 2 * PB;
   localparam int CD  = PROFILE_COUNT * PROFILE_COUNT;
   localparam int SW  = 1 + 32 + TAG_BITS + 6;
   localparam logic [COUNT_BITS-1:0] CMAX = '1;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_LOOK  = 3'd2;
   localparam logic [2:0] ST_CNT   = 3'd3;
   localparam logic [2:0] ST_WRITE = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   logic [SW-1:0]         ring [WINDOW_DEPTH];
   logic [COUNT_BITS-1:0] counts [CD];
   logic [PROFILE_COUNT-1:0] incl_ff;

   logic [2:0]    state_ff;
   logic [WB:0]   wclr_ff;
   logic [CB:0]   cclr_ff;
   item_type      it_ff;
   logic [SW-1:0] slot_ff;
   logic [COUNT_BITS-1:0] crd_ff;
   logic [TAG_BITS-1:0]   tag_ff;
   logic [31:0]   total_ff;
   logic          look_ff;
   logic [31:0]   target_ff;
   logic [5:0]    lo_ff, hi_ff;
   logic          hit_ff;
   logic          okc_ff;
   logic          found_ff;
   logic [31:0]   cnt_out_ff;

   logic [5:0]  sprof, lo_in, hi_in;
   logic        s_inc, m_inc, hit_in, lo_ok, hi_ok;
   logic [CB-1:0] caddr;
   logic [COUNT_BITS-1:0] cnew;
   logic [31:0] tgt;

   assign in_take = (state_ff == ST_IDLE) && in_valid;
   assign tgt     = in_item.position - {22'd0, distance};

   // Slot fields and pair ordering.
   assign sprof = slot_ff[5:0];
   assign s_inc = ({26'd0, sprof} < PROFILE_COUNT) && incl_ff[sprof[PB-1:0]];
   assign m_inc = ({26'd0, it_ff.profile} < PROFILE_COUNT)
                  && incl_ff[it_ff.profile[PB-1:0]];
   assign hit_in = look_ff && slot_ff[SW-1]
                   && (slot_ff[SW-2 -: 32] == target_ff)
                   && (slot_ff[SW-2-32 -: TAG_BITS] == tag_ff)
                   && s_inc && m_inc;
   always_comb begin
      if (it_ff.action == ACT_SITE) begin
         lo_in = (sprof < it_ff.profile) ? sprof : it_ff.profile;
         hi_in = (sprof < it_ff.profile) ? it_ff.profile : sprof;
      end else begin
         lo_in = (it_ff.profile < it_ff.other_profile) ? it_ff.profile
                                                        : it_ff.other_profile;
         hi_in = (it_ff.profile < it_ff.other_profile) ? it_ff.other_profile
                                                        : it_ff.profile;
      end
   end
   assign lo_ok = {26'd0, lo_ff} < PROFILE_COUNT;
   assign hi_ok = {26'd0, hi_ff} < PROFILE_COUNT;
   assign caddr = {hi_ff[PB-1:0], lo_ff[PB-1:0]};
   assign cnew  = (crd_ff == CMAX) ? crd_ff : crd_ff + 1'b1;

   // Memories: ring and count table, registered reads.
   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR && !wclr_ff[WB]) begin
         ring[wclr_ff[WB-1:0]] <= '0;
      end else if (state_ff == ST_WRITE && it_ff.action == ACT_SITE) begin
         ring[it_ff.position[WB-1:0]] <= {1'b1, it_ff.position, tag_ff,
                                           it_ff.profile};
      end
      if (in_take) begin
         slot_ff <= ring[tgt[WB-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR && !cclr_ff[CB]) begin
         counts[cclr_ff[CB-1:0]] <= '0;
      end else if (state_ff == ST_WRITE && hit_ff) begin
         counts[caddr] <= cnew;
      end
      if (state_ff == ST_LOOK) begin
         crd_ff <= counts[{hi_in[PB-1:0], lo_in[PB-1:0]}];
      end
   end

   // Sequencer and control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         wclr_ff  <= '0;
         cclr_ff  <= '0;
         incl_ff  <= '1;
         tag_ff   <= '0;
         total_ff <= '0;
      end else begin
         unique case (state_ff)
            ST_CLEAR: begin
               if (!wclr_ff[WB]) wclr_ff <= wclr_ff + 1'b1;
               if (!cclr_ff[CB]) cclr_ff <= cclr_ff + 1'b1;
               if (wclr_ff[WB] && cclr_ff[CB]) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (in_take) begin
                  it_ff     <= in_item;
                  target_ff <= tgt;
                  look_ff   <= (distance != 10'd0)
                               && (in_item.position >= {22'd0, distance});
                  if (in_item.action == ACT_SITE && in_item.new_contig) begin
                     tag_ff <= tag_ff + 1'b1;
                  end
                  state_ff <= ST_LOOK;
               end
            end
            ST_LOOK: begin
               hit_ff <= (it_ff.action == ACT_SITE) && hit_in;
               lo_ff  <= lo_in;
               hi_ff  <= hi_in;
               state_ff <= ST_CNT;
            end
            ST_CNT: begin
               state_ff <= ST_WRITE;
            end
            ST_WRITE: begin
               found_ff <= hit_ff;
               if (hit_ff) begin
                  cnt_out_ff <= cnew[31:0];
                  if (total_ff != 32'hFFFF_FFFF) total_ff <= total_ff + 32'd1;
               end else if (it_ff.action == ACT_READ && lo_ok && hi_ok) begin
                  cnt_out_ff <= crd_ff[31:0];
               end else begin
                  cnt_out_ff <= '0;
               end
               okc_ff <= hit_ff || it_ff.action == ACT_READ;
               if (it_ff.action == ACT_SET
                   && {26'd0, it_ff.profile} < PROFILE_COUNT) begin
                  incl_ff[it_ff.profile[PB-1:0]] <= it_ff.include_value;
               end
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (!rsp_stall) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid        = (state_ff == ST_OUT);
   assign rsp_pair_found   = found_ff;
   assign rsp_low_profile  = okc_ff ? lo_ff : 6'd0;
   assign rsp_high_profile = okc_ff ? hi_ff : 6'd0;
   assign rsp_pair_count   = cnt_out_ff;
   assign rsp_total_pairs  = total_ff;

   // A pair is only reported for a site item.
   a_found_site: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pair_found |-> it_ff.action == ACT_SITE)
      else $error("pair reported for non-site item");
   // No item is taken while clearing.
   a_no_take_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !in_take)
      else $error("item taken during clear");
   // Total never decreases.
   a_total_mono: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_CLEAR |=> total_ff >= $past(total_ff))
      else $error("total decreased");

endmodule
